// File: rtl/u8v_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8v_pkg: shared types and helpers for the UTF-8 stream validator
// Byte classes produced by the front end, continuation range rules and the
// queue entry that carries one classified byte to the back end.
// ----------------------------------------------------------------------------
package u8v_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [3:0] {
		CLS_ASCII    = 4'd0,
		CLS_CONT_LO  = 4'd1,
		CLS_CONT_MID = 4'd2,
		CLS_CONT_HI  = 4'd3,
		CLS_LEAD2    = 4'd4,
		CLS_LEAD3_E0 = 4'd5,
		CLS_LEAD3_ED = 4'd6,
		CLS_LEAD3    = 4'd7,
		CLS_LEAD4_F0 = 4'd8,
		CLS_LEAD4_F4 = 4'd9,
		CLS_LEAD4    = 4'd10,
		CLS_BAD      = 4'd11
	} byte_class_t;

	typedef enum logic [2:0] {
		RULE_ANY   = 3'd0,
		RULE_A0_BF = 3'd1,
		RULE_80_9F = 3'd2,
		RULE_90_BF = 3'd3,
		RULE_80_8F = 3'd4
	} rule_t;

	typedef struct packed {
		byte_class_t cls;
		logic        last;
	} item_t;

	function automatic byte_class_t classify(input logic [7:0] b);
		byte_class_t c;
		c = CLS_BAD;
		if (b <= 8'h7F) begin
			c = CLS_ASCII;
		end else if (b <= 8'h8F) begin
			c = CLS_CONT_LO;
		end else if (b <= 8'h9F) begin
			c = CLS_CONT_MID;
		end else if (b <= 8'hBF) begin
			c = CLS_CONT_HI;
		end else if (b >= 8'hC2 && b <= 8'hDF) begin
			c = CLS_LEAD2;
		end else if (b == 8'hE0) begin
			c = CLS_LEAD3_E0;
		end else if (b == 8'hED) begin
			c = CLS_LEAD3_ED;
		end else if (b >= 8'hE1 && b <= 8'hEF) begin
			c = CLS_LEAD3;
		end else if (b == 8'hF0) begin
			c = CLS_LEAD4_F0;
		end else if (b == 8'hF4) begin
			c = CLS_LEAD4_F4;
		end else if (b >= 8'hF1 && b <= 8'hF3) begin
			c = CLS_LEAD4;
		end
		return c;
	endfunction

	function automatic logic in_range(input byte_class_t c, input rule_t r);
		logic ok;
		case (r)
			RULE_A0_BF: begin
				ok = (c == CLS_CONT_HI);
			end
			RULE_80_9F: begin
				ok = (c == CLS_CONT_LO) || (c == CLS_CONT_MID);
			end
			RULE_90_BF: begin
				ok = (c == CLS_CONT_MID) || (c == CLS_CONT_HI);
			end
			RULE_80_8F: begin
				ok = (c == CLS_CONT_LO);
			end
			default: begin
				ok = (c == CLS_CONT_LO) || (c == CLS_CONT_MID) || (c == CLS_CONT_HI);
			end
		endcase
		return ok;
	endfunction

endpackage
`default_nettype wire

// File: rtl/utf8_stream_validator.sv
// A string's verdict is registered after its final byte passes the front stage and queue.
// Throughput: one byte per cycle while in_stall is low; the front stage, a four-entry queue
// and the back-end state update each move one byte per cycle when not stalled.
// A stalled verdict holds only the next final byte; it and up to four later bytes
// wait in the queue and the front stage before the input stalls.
// Reset (arst_n low) clears the queue, the sequence state and the output valid.
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_validator: strict UTF-8 check over a byte stream
// Classifies each byte, queues it and checks multibyte sequences, giving one
// valid or invalid verdict at the end of each string.
// ----------------------------------------------------------------------------
module utf8_stream_validator (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] byte_value,
	input  wire        last_byte,
	output logic       out_valid,
	input  wire        out_stall,
	output logic       is_valid
);

	logic           push;
	logic           pop;
	logic           fifo_full;
	logic           fifo_empty;
	u8v_pkg::item_t push_data;
	u8v_pkg::item_t pop_data;

	u8v_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_data  (push_data)
	);

	u8v_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (fifo_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (fifo_empty)
	);

	u8v_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (fifo_empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.is_valid  (is_valid)
	);

endmodule
`default_nettype wire

// File: rtl/u8v_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8v_front: input stage
// Accepts one byte per cycle unless in_stall is raised because the queue is full,
// classifies it and hands it to the queue.
module u8v_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire  [7:0]             byte_value,
	input  wire                    last_byte,
	input  wire                    fifo_full,
	output logic                   push,
	output u8v_pkg::item_t         push_data
);

	logic           valid_s1;
	u8v_pkg::item_t item_s1;

	assign in_stall  = valid_s1 && fifo_full;
	assign push      = valid_s1 && !fifo_full;
	assign push_data = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.cls  <= u8v_pkg::classify(byte_value);
			item_s1.last <= last_byte;
		end
	end

endmodule
`default_nettype wire

// File: rtl/u8v_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8v_fifo: decoupling queue
// A short queue of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module u8v_fifo (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  u8v_pkg::item_t         push_data,
	output logic                   full,
	input  wire                    pop,
	output u8v_pkg::item_t         pop_data,
	output logic                   empty
);

	u8v_pkg::item_t                       entry_q [u8v_pkg::FIFO_DEPTH];
	logic [u8v_pkg::FIFO_AW-1:0]          wr_ptr_q;
	logic [u8v_pkg::FIFO_AW-1:0]          rd_ptr_q;
	logic [u8v_pkg::FIFO_CW-1:0]          count_q;

	assign full     = (count_q == u8v_pkg::FIFO_CW'(u8v_pkg::FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

// File: rtl/u8v_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8v_back: sequence checker
// Tracks the open multibyte sequence and presents one verdict per string.
// ----------------------------------------------------------------------------
module u8v_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    empty,
	input  u8v_pkg::item_t         pop_data,
	output logic                   pop,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic                   is_valid
);

	logic [1:0]            exp_q;
	u8v_pkg::rule_t        rule_q;
	logic                  await_q;
	logic                  err_q;
	logic                  out_valid_q;
	logic                  is_valid_q;

	logic [1:0]            exp_n;
	u8v_pkg::rule_t        rule_n;
	u8v_pkg::rule_t        rule_sel;
	logic                  await_n;
	logic                  err_n;
	logic                  result;

	assign pop       = !empty && (!pop_data.last || !out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign is_valid  = is_valid_q;

	always_comb begin
		exp_n    = exp_q;
		rule_n   = rule_q;
		await_n  = await_q;
		err_n    = err_q;
		rule_sel = u8v_pkg::RULE_ANY;
		if (await_q) begin
			rule_sel = rule_q;
		end
		if (!err_q) begin
			if (exp_q != 2'd0) begin
				if (!u8v_pkg::in_range(pop_data.cls, rule_sel)) begin
					err_n = 1'b1;
				end
				exp_n   = exp_q - 2'd1;
				await_n = 1'b0;
				rule_n  = u8v_pkg::RULE_ANY;
			end else begin
				case (pop_data.cls)
					u8v_pkg::CLS_ASCII: begin
					end
					u8v_pkg::CLS_LEAD2: begin
						exp_n   = 2'd1;
						rule_n  = u8v_pkg::RULE_ANY;
						await_n = 1'b1;
					end
					u8v_pkg::CLS_LEAD3_E0: begin
						exp_n   = 2'd2;
						rule_n  = u8v_pkg::RULE_A0_BF;
						await_n = 1'b1;
					end
					u8v_pkg::CLS_LEAD3_ED: begin
						exp_n   = 2'd2;
						rule_n  = u8v_pkg::RULE_80_9F;
						await_n = 1'b1;
					end
					u8v_pkg::CLS_LEAD3: begin
						exp_n   = 2'd2;
						rule_n  = u8v_pkg::RULE_ANY;
						await_n = 1'b1;
					end
					u8v_pkg::CLS_LEAD4_F0: begin
						exp_n   = 2'd3;
						rule_n  = u8v_pkg::RULE_90_BF;
						await_n = 1'b1;
					end
					u8v_pkg::CLS_LEAD4_F4: begin
						exp_n   = 2'd3;
						rule_n  = u8v_pkg::RULE_80_8F;
						await_n = 1'b1;
					end
					u8v_pkg::CLS_LEAD4: begin
						exp_n   = 2'd3;
						rule_n  = u8v_pkg::RULE_ANY;
						await_n = 1'b1;
					end
					default: begin
						err_n = 1'b1;
					end
				endcase
			end
		end
		result = !err_n && (exp_n == 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q       <= 2'd0;
			rule_q      <= u8v_pkg::RULE_ANY;
			await_q     <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (pop_data.last) begin
					exp_q   <= 2'd0;
					rule_q  <= u8v_pkg::RULE_ANY;
					await_q <= 1'b0;
					err_q   <= 1'b0;
				end else begin
					exp_q   <= exp_n;
					rule_q  <= rule_n;
					await_q <= await_n;
					err_q   <= err_n;
				end
			end
			if (pop && pop_data.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_data.last) begin
			is_valid_q <= result;
		end
	end

endmodule
`default_nettype wire

// File: rtl/u8v_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8v_checker: port-level checks for the UTF-8 stream validator
// Counts strings in flight and checks verdicts against them.
// ----------------------------------------------------------------------------
module u8v_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_stall,
	input wire [7:0] byte_value,
	input wire       last_byte,
	input wire       out_valid,
	input wire       out_stall,
	input wire       is_valid
);

	logic [3:0] pending_q;
	logic       in_last_xfer;
	logic       out_xfer;

	assign in_last_xfer = in_valid && !in_stall && last_byte;
	assign out_xfer     = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 4'd0;
		end else if (in_last_xfer && !out_xfer) begin
			pending_q <= pending_q + 4'd1;
		end else if (out_xfer && !in_last_xfer) begin
			pending_q <= pending_q - 4'd1;
		end
	end

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !in_stall && !out_valid)
		else $error("Stall or output valid active during reset.");

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 4'd0)
		else $error("Verdict presented without a final byte accepted.");

	a_bounded_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'd6)
		else $error("More strings in flight than the pipeline can hold.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(is_valid))
		else $error("Stalled verdict changed or was dropped.");

	a_byte_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> !$isunknown(byte_value))
		else $error("Accepted transaction carries unknown byte bits.");

endmodule

bind utf8_stream_validator u8v_checker u_u8v_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.byte_value (byte_value),
	.last_byte  (last_byte),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.is_valid   (is_valid)
);
`default_nettype wire
